// ===== hw/rtl/vamw_pkg.sv =====
// shared constants, types and command/status structs for the velocity axis mapper
package vamw_pkg;

    localparam int VELOCITY_BITS = 16;
    localparam int MAG_W         = VELOCITY_BITS + 1;
    localparam int LIM_W         = 15;
    localparam int CMP_W         = (MAG_W > LIM_W) ? MAG_W : LIM_W;
    localparam int AXIS_W        = 16;
    localparam int TICK_W        = 17;
    localparam int WDT_W         = 16;
    localparam int NUM_W         = 32;
    localparam int DIV_W         = LIM_W + 1;
    localparam int REM_W         = DIV_W + 1;
    localparam int CNT_W         = $clog2(NUM_W);
    localparam int N_AXES        = 3;
    localparam int APB_W         = 32;
    localparam int ADDR_W        = 5;
    localparam int IDX_W         = ADDR_W - 2;

    typedef logic [LIM_W-1:0] t_lim;

    localparam t_lim              AXIS_MAX = 15'd32767;
    localparam logic [TICK_W-1:0] TICK_SAT = '1;

    // deadzones per axis: vx, vy, yaw
    localparam t_lim DZ [N_AXES]   = '{15'd6553, 15'd24576, 15'd28212};
    localparam t_lim SPAN [N_AXES] = '{AXIS_MAX - 15'd6553,
                                       AXIS_MAX - 15'd24576,
                                       AXIS_MAX - 15'd28212};

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_VX    = 3'd0,
        REG_MAX_VY    = 3'd1,
        REG_MAX_YAW   = 3'd2,
        REG_INV_VY    = 3'd3,
        REG_INV_YAW   = 3'd4,
        REG_TIMEOUT   = 3'd5,
        REG_ZERO_HOLD = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_MUL,
        S_NUM,
        S_DIV,
        S_TICK,
        S_EMIT
    } t_ctrl_state;

    typedef struct packed {
        logic [N_AXES-1:0][LIM_W-1:0] lim;
        logic [N_AXES-1:0]            inv;
        logic [WDT_W-1:0]             timeout;
        logic [WDT_W-1:0]             hold;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic clamp;
        logic mul;
        logic num;
        logic div_step;
        logic tick;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic tick_emit;
        logic out_valid;
    } t_dp_sts;

endpackage

// ===== hw/rtl/vamw_if.sv =====
// valid/ready channel interfaces for input beats and result beats
interface vamw_in_if;
    import vamw_pkg::*;

    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic signed [VELOCITY_BITS-1:0] vx;
    logic signed [VELOCITY_BITS-1:0] vy;
    logic signed [VELOCITY_BITS-1:0] turn_rate;

    modport source (output valid, kind, vx, vy, turn_rate, input ready);
    modport sink   (input valid, kind, vx, vy, turn_rate, output ready);
endinterface

interface vamw_out_if;
    import vamw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] vx_axis;
    logic signed [AXIS_W-1:0] vy_axis;
    logic signed [AXIS_W-1:0] turn_axis;
    logic                     from_watchdog;

    modport source (output valid, vx_axis, vy_axis, turn_axis, from_watchdog, input ready);
    modport sink   (input valid, vx_axis, vy_axis, turn_axis, from_watchdog, output ready);
endinterface

// ===== hw/rtl/velocity_axis_mapper_watchdog_top.sv =====
// top level: configuration registers, controller and datapath of the axis mapper
//
//  channel   dir   handshake          payload
//  i_in      in    valid/ready        kind, vx, vy, turn_rate
//  o_out     out   valid/ready        vx_axis, vy_axis, turn_axis, from_watchdog
//  apb       in    psel/penable       paddr, pwdata, prdata (pready tied high)
//
// a velocity command runs clamp, multiply, numerator add, then a 32-step
// restoring divider (one quotient bit per cycle, all three axes in parallel),
// and then loads the output register once that register is free
// a tick can also emit a watchdog zero beat
// i_rst_n is synchronous and active low; it disarms the watchdog and loads
// the register reset values
// a stalled output beat holds in the output register; the next input is still
// taken and only its own result waits for the register to drain
module velocity_axis_mapper_watchdog_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    vamw_in_if.sink                     i_in,
    vamw_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vamw_pkg::ADDR_W-1:0] paddr,
    input  logic [vamw_pkg::APB_W-1:0]  pwdata,
    output logic [vamw_pkg::APB_W-1:0]  prdata,
    output logic                        pready
);
    import vamw_pkg::*;

    // configuration registers
    logic [LIM_W-1:0] r_max_vx;
    logic [LIM_W-1:0] r_max_vy;
    logic [LIM_W-1:0] r_max_yaw;
    logic             r_inv_vy;
    logic             r_inv_yaw;
    logic [WDT_W-1:0] r_timeout;
    logic [WDT_W-1:0] r_hold;

    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vx  <= LIM_W'(1000);
            r_max_vy  <= LIM_W'(1000);
            r_max_yaw <= LIM_W'(1000);
            r_inv_vy  <= 1'b0;
            r_inv_yaw <= 1'b0;
            r_timeout <= WDT_W'(5);
            r_hold    <= WDT_W'(5);
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_VX:    r_max_vx  <= pwdata[LIM_W-1:0];
                REG_MAX_VY:    r_max_vy  <= pwdata[LIM_W-1:0];
                REG_MAX_YAW:   r_max_yaw <= pwdata[LIM_W-1:0];
                REG_INV_VY:    r_inv_vy  <= pwdata[0];
                REG_INV_YAW:   r_inv_yaw <= pwdata[0];
                REG_TIMEOUT:   r_timeout <= pwdata[WDT_W-1:0];
                REG_ZERO_HOLD: r_hold    <= pwdata[WDT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback, unused addresses read zero
    always_comb begin
        case (w_idx)
            REG_MAX_VX:    prdata = APB_W'(r_max_vx);
            REG_MAX_VY:    prdata = APB_W'(r_max_vy);
            REG_MAX_YAW:   prdata = APB_W'(r_max_yaw);
            REG_INV_VY:    prdata = APB_W'(r_inv_vy);
            REG_INV_YAW:   prdata = APB_W'(r_inv_yaw);
            REG_TIMEOUT:   prdata = APB_W'(r_timeout);
            REG_ZERO_HOLD: prdata = APB_W'(r_hold);
            default:       prdata = '0;
        endcase
    end

    // lane order is vx, vy, yaw; vx never inverts
    t_cfg w_cfg;
    assign w_cfg.lim     = {r_max_yaw, r_max_vy, r_max_vx};
    assign w_cfg.inv     = {r_inv_yaw, r_inv_vy, 1'b0};
    assign w_cfg.timeout = r_timeout;
    assign w_cfg.hold    = r_hold;

    t_dp_cmd                             w_cmd;
    t_dp_sts                             w_sts;
    logic                                w_in_ready;
    logic [N_AXES-1:0][VELOCITY_BITS-1:0] w_vel;
    logic [N_AXES-1:0][AXIS_W-1:0]       w_axis;
    logic                                w_out_valid;
    logic                                w_from_wd;

    assign w_vel = {i_in.turn_rate, i_in.vy, i_in.vx};

    vamw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd)
    );

    vamw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_vel       (w_vel),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_axis      (w_axis),
        .o_from_wd   (w_from_wd)
    );

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = w_out_valid;
    assign o_out.vx_axis       = w_axis[0];
    assign o_out.vy_axis       = w_axis[1];
    assign o_out.turn_axis     = w_axis[2];
    assign o_out.from_watchdog = w_from_wd;

endmodule

// ===== hw/rtl/vamw_ctrl.sv =====
// controller state machine sequencing clamp, multiply, divide, watchdog and output
module vamw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    input  logic              i_out_ready,
    input  vamw_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output vamw_pkg::t_dp_cmd o_cmd
);
    import vamw_pkg::*;

    t_ctrl_state      r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_in_kind == KIND_TICK) ? S_TICK : S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_NUM;
            end
            S_NUM: begin
                o_cmd.num = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                n_state    = i_sts.tick_emit ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!i_sts.out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // step counter only runs during division
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_DIV |-> r_cnt == '0)
        else $error("division counter nonzero outside division");

    // a result is only reached from the divider or a watchdog tick
    a_emit_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && $past(r_state) != S_EMIT
            |-> $past(r_state) == S_DIV || $past(r_state) == S_TICK)
        else $error("emit entered from unexpected state");

endmodule

// ===== hw/rtl/vamw_datapath.sv =====
// per-axis clamp, scale multiply and restoring divider, watchdog counter, output register
module vamw_datapath (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  vamw_pkg::t_cfg                                       i_cfg,
    input  vamw_pkg::t_dp_cmd                                    i_cmd,
    input  logic [vamw_pkg::N_AXES-1:0][vamw_pkg::VELOCITY_BITS-1:0] i_vel,
    input  logic                                                 i_out_ready,
    output vamw_pkg::t_dp_sts                                    o_sts,
    output logic                                                 o_out_valid,
    output logic [vamw_pkg::N_AXES-1:0][vamw_pkg::AXIS_W-1:0]    o_axis,
    output logic                                                 o_from_wd
);
    import vamw_pkg::*;

    wire [N_AXES-1:0][AXIS_W-1:0] w_lane_axis;
    wire [N_AXES-1:0]             w_lane_nz;

    for (genvar g = 0; g < N_AXES; g++) begin : g_lane
        logic [VELOCITY_BITS-1:0] r_vel;
        logic [LIM_W-1:0]         r_mag;
        logic                     r_neg;
        logic                     r_nz;
        logic [2*LIM_W-1:0]       r_prod;
        logic [NUM_W-1:0]         r_num;
        logic [REM_W-1:0]         r_rem;
        logic [MAG_W-1:0]         w_ext;
        logic [MAG_W-1:0]         w_abs;
        logic [LIM_W-1:0]         w_clamp;
        logic [DIV_W-1:0]         w_divisor;
        logic [REM_W-1:0]         w_shift;
        logic [REM_W:0]           w_diff;
        logic                     w_ge;
        logic [AXIS_W-1:0]        w_mag;

        // magnitude of the raw velocity, then symmetric clamp
        assign w_ext   = {r_vel[VELOCITY_BITS-1], r_vel};
        assign w_abs   = w_ext[MAG_W-1] ? (~w_ext + 1'b1) : w_ext;
        assign w_clamp = (CMP_W'(w_abs) > CMP_W'(i_cfg.lim[g])) ? i_cfg.lim[g]
                                                                : LIM_W'(CMP_W'(w_abs));

        // restoring step, divisor is twice the limit
        assign w_divisor = {i_cfg.lim[g], 1'b0};
        assign w_shift   = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
        assign w_diff    = {1'b0, w_shift} - {2'b00, w_divisor};
        assign w_ge      = !w_diff[REM_W];

        // deadzone offset, saturated at full scale
        assign w_mag = (r_num > NUM_W'(SPAN[g])) ? AXIS_W'(AXIS_MAX)
                                                 : AXIS_W'(DZ[g]) + AXIS_W'(r_num[LIM_W-1:0]);

        assign w_lane_nz[g]   = r_nz;
        assign w_lane_axis[g] = !r_nz ? '0 :
                                (r_neg ^ i_cfg.inv[g]) ? (~w_mag + 1'b1) : w_mag;

        always_ff @(posedge i_clk) begin
            if (i_cmd.capture) begin
                r_vel <= i_vel[g];
            end
            if (i_cmd.clamp) begin
                r_mag <= w_clamp;
                r_neg <= r_vel[VELOCITY_BITS-1];
                r_nz  <= (w_clamp != '0);
            end
            if (i_cmd.mul) begin
                r_prod <= (2*LIM_W)'(r_mag) * (2*LIM_W)'(SPAN[g]);
            end
            if (i_cmd.num) begin
                r_num <= NUM_W'({r_prod, 1'b0}) + NUM_W'(i_cfg.lim[g]);
                r_rem <= '0;
            end else if (i_cmd.div_step) begin
                r_num <= {r_num[NUM_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[REM_W-1:0] : w_shift;
            end
        end
    end

    logic                          r_active;
    logic [TICK_W-1:0]             r_ticks;
    logic                          r_wd;
    logic                          r_out_valid;
    logic [N_AXES-1:0][AXIS_W-1:0] r_out_axis;
    logic                          r_out_wd;
    logic [TICK_W-1:0]             w_ticks_inc;
    logic [TICK_W-1:0]             w_hi;
    logic                          w_emit;
    logic                          w_past;

    assign w_ticks_inc = (r_ticks == TICK_SAT) ? r_ticks : r_ticks + 1'b1;
    assign w_hi        = TICK_W'(i_cfg.timeout) + TICK_W'(i_cfg.hold);
    assign w_emit      = r_active && (w_ticks_inc >= TICK_W'(i_cfg.timeout))
                         && (w_ticks_inc <= w_hi);
    assign w_past      = w_ticks_inc > w_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_ticks     <= '0;
            r_wd        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mul) begin
                r_active <= |w_lane_nz;
                r_ticks  <= '0;
                r_wd     <= 1'b0;
            end else if (i_cmd.tick) begin
                r_ticks <= w_ticks_inc;
                r_wd    <= 1'b1;
                if (r_active && w_past) begin
                    r_active <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_axis <= r_wd ? '0 : w_lane_axis;
            r_out_wd   <= r_wd;
        end
    end

    assign o_sts.tick_emit = w_emit;
    assign o_sts.out_valid = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_axis          = r_out_axis;
    assign o_from_wd       = r_out_wd;

    // watchdog beats carry all-zero axes
    a_wd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_wd |-> r_out_axis == '0)
        else $error("watchdog beat with nonzero axis");

    // a watchdog result only goes out while armed
    a_wd_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && r_wd |-> r_active)
        else $error("watchdog beat while disarmed");

    // a saturated counter is always past the window
    a_sat_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ticks == TICK_SAT |-> !w_emit)
        else $error("saturated tick count opened the window");

endmodule
